### rtl/core/assert_macros.svh
// assertion macros shared by the rtl files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every clock out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/core/bsc_pkg.sv
// types, key codes and the character code table of the button encoder
// no dependencies
package bsc_pkg;

	localparam int CODE_COUNT_DEF = 48;
	localparam int POS_W          = 6;
	localparam int CODE_W         = 7;
	localparam int MASK_W         = 7;

	// key codes
	localparam logic [CODE_W-1:0] KEY_ENTER  = 7'd28;
	localparam logic [CODE_W-1:0] KEY_ESC    = 7'd15;
	localparam logic [CODE_W-1:0] KEY_UP     = 7'd103;
	localparam logic [CODE_W-1:0] KEY_DOWN   = 7'd108;
	localparam logic [CODE_W-1:0] KEY_RIGHT  = 7'd106;
	localparam logic [CODE_W-1:0] KEY_LEFT   = 7'd105;
	localparam logic [CODE_W-1:0] KEY_DELETE = 7'h53;
	localparam logic [CODE_W-1:0] KEY_SHIFT  = 7'h2a;
	localparam logic [CODE_W-1:0] KEY_SPACE  = 7'h39;
	localparam logic [CODE_W-1:0] KEY_CTRL   = 7'h1d;
	localparam logic [CODE_W-1:0] KEY_C      = 7'h2e;
	localparam logic [CODE_W-1:0] KEY_NONE   = 7'd0;

	// button slots of the plain mask, in emit order
	localparam logic [2:0] BTN_OK    = 3'd0;
	localparam logic [2:0] BTN_ESC   = 3'd1;
	localparam logic [2:0] BTN_UP    = 3'd2;
	localparam logic [2:0] BTN_DOWN  = 3'd3;
	localparam logic [2:0] BTN_RIGHT = 3'd4;
	localparam logic [2:0] BTN_LEFT  = 3'd5;
	localparam logic [2:0] BTN_POWER = 3'd6;

	// character table; positions past the list read as zero
	localparam logic [CODE_W-1:0] CODE_TABLE [64] = '{
		7'h1e, 7'h30, 7'h2e, 7'h20, 7'h12, 7'h21, 7'h22, 7'h23,
		7'h17, 7'h24, 7'h25, 7'h26, 7'h32, 7'h31, 7'h18, 7'h19,
		7'h10, 7'h13, 7'h1f, 7'h14, 7'h16, 7'h2f, 7'h11, 7'h2d,
		7'h15, 7'h2c, 7'h39, 7'h02, 7'h03, 7'h04, 7'h05, 7'h06,
		7'h07, 7'h08, 7'h09, 7'h0a, 7'h0b, 7'h29, 7'h0c, 7'h0d,
		7'h1a, 7'h1b, 7'h27, 7'h28, 7'h2b, 7'h33, 7'h34, 7'h35,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	// sequence kinds handed from front to back
	typedef enum logic [2:0] {
		SEQ_PLAIN   = 3'd0,
		SEQ_REPLAY  = 3'd1,
		SEQ_TAP     = 3'd2,
		SEQ_TAP_TWO = 3'd3,
		SEQ_POWER   = 3'd4
	} seq_kind_t;

	typedef struct packed {
		seq_kind_t         kind;
		logic [MASK_W-1:0] mask;       // plain: pressed buttons by slot
		logic [CODE_W-1:0] code;       // replay: table code, tap: key code
		logic              caps_evt;   // replay: position wrapped
		logic              caps_down;  // replay: shift press when set
	} seq_desc_t;

	// key code of a plain button slot
	function automatic logic [CODE_W-1:0] plain_code(input logic [2:0] slot);
		logic [CODE_W-1:0] c;
		case (slot)
			BTN_OK:    c = KEY_ENTER;
			BTN_ESC:   c = KEY_ESC;
			BTN_UP:    c = KEY_UP;
			BTN_DOWN:  c = KEY_DOWN;
			BTN_RIGHT: c = KEY_RIGHT;
			BTN_LEFT:  c = KEY_LEFT;
			default:   c = KEY_NONE;
		endcase
		return c;
	endfunction

endpackage

### rtl/core/bsc_queue.sv
// two-entry queue of sequence descriptors between front and back
// depends on bsc_pkg
module bsc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  bsc_pkg::seq_desc_t wdata,
	output logic               full,
	input  logic               pop,
	output bsc_pkg::seq_desc_t rdata,
	output logic               empty
);
	import bsc_pkg::*;

	seq_desc_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop) count_q <= count_q + 2'd1;
			else if (do_pop && !do_push) count_q <= count_q - 2'd1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wdata;
	end

endmodule

### rtl/core/bsc_front.sv
// front: takes poll transactions, keeps position and caps state, classifies
// depends on bsc_pkg and assert_macros.svh
`include "assert_macros.svh"
module bsc_front #(
	parameter int CODE_COUNT = bsc_pkg::CODE_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         button_bits_low,
	input  logic [7:0]         button_bits_high,
	output logic               q_push,
	input  logic               q_full,
	output bsc_pkg::seq_desc_t q_desc
);
	import bsc_pkg::*;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(CODE_COUNT - 1);

	logic [POS_W-1:0] char_position_q;
	logic             caps_active_q;
	logic [POS_W-1:0] pos_d;
	logic             caps_d;
	logic             accept;
	logic             has_results;
	logic             wrap;
	seq_desc_t        desc;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign q_push = accept && has_results;
	assign q_desc = desc;

	// classify the poll and work out the next position
	always_comb begin
		desc        = '0;
		desc.kind   = SEQ_PLAIN;
		has_results = 1'b0;
		pos_d       = char_position_q;
		caps_d      = caps_active_q;
		wrap        = 1'b0;
		if (button_bits_high[4]) begin
			if (button_bits_low[4]) begin
				desc.kind      = SEQ_REPLAY;
				desc.code      = CODE_TABLE[char_position_q];
				wrap           = (char_position_q >= LAST_POS);
				pos_d          = wrap ? '0 : char_position_q + POS_W'(1);
				has_results    = 1'b1;
			end else if (button_bits_low[5]) begin
				desc.kind      = SEQ_REPLAY;
				desc.code      = CODE_TABLE[char_position_q];
				wrap           = (char_position_q == '0);
				pos_d          = wrap ? LAST_POS : char_position_q - POS_W'(1);
				has_results    = 1'b1;
			end else if (button_bits_low[6]) begin
				desc.kind   = SEQ_TAP;
				desc.code   = KEY_RIGHT;
				has_results = 1'b1;
			end else if (button_bits_low[7]) begin
				desc.kind   = SEQ_TAP;
				desc.code   = KEY_LEFT;
				has_results = 1'b1;
			end else if (button_bits_low[2]) begin
				desc.kind   = SEQ_TAP;
				desc.code   = KEY_SPACE;
				has_results = 1'b1;
			end else if (button_bits_low[3]) begin
				desc.kind   = SEQ_TAP_TWO;
				has_results = 1'b1;
			end else if (button_bits_high[7]) begin
				desc.kind   = SEQ_POWER;
				has_results = 1'b1;
			end
			if (wrap) begin
				desc.caps_evt  = 1'b1;
				desc.caps_down = ~caps_active_q;
				caps_d         = ~caps_active_q;
			end
		end else begin
			desc.mask   = {button_bits_high[7], button_bits_low[7:2]};
			has_results = (desc.mask != '0);
		end
	end

	// kept state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_position_q <= '0;
			caps_active_q   <= 1'b0;
		end else if (accept) begin
			char_position_q <= pos_d;
			caps_active_q   <= caps_d;
		end
	end

	`ASSERT_ALWAYS(a_pos_in_range, clk, arst_n, char_position_q <= LAST_POS)

endmodule

### rtl/core/bsc_back.sv
// back: a descriptor's key events to the result register, one per cycle unless stalled
// depends on bsc_pkg and assert_macros.svh
`include "assert_macros.svh"
module bsc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	output logic               q_pop,
	input  bsc_pkg::seq_desc_t q_desc,
	input  logic               pop,
	output logic               empty,
	output logic [6:0]         scancode,
	output logic               key_down,
	output logic               reset_request,
	output logic               last
);
	import bsc_pkg::*;

	seq_desc_t         desc_q;
	logic              busy_q;
	logic [MASK_W-1:0] mask_q;
	logic [2:0]        step_q;
	logic              phase_q;
	logic              out_valid_q;
	logic [CODE_W-1:0] scancode_q;
	logic              key_down_q;
	logic              reset_request_q;
	logic              last_q;

	logic              adv;
	logic [CODE_W-1:0] ev_code;
	logic              ev_down;
	logic              ev_rst;
	logic              ev_last;
	logic [MASK_W-1:0] mask_next;
	logic              phase_next;
	logic [2:0]        cur_slot;
	logic [2:0]        last_step;

	assign q_pop = !busy_q && !q_empty;
	assign adv   = busy_q && (!out_valid_q || pop);

	assign empty         = !out_valid_q;
	assign scancode      = scancode_q;
	assign key_down      = key_down_q;
	assign reset_request = reset_request_q;
	assign last          = last_q;

	// event at the current step
	always_comb begin
		ev_code    = KEY_NONE;
		ev_down    = 1'b0;
		ev_rst     = 1'b0;
		ev_last    = 1'b0;
		mask_next  = mask_q;
		phase_next = phase_q;
		cur_slot   = BTN_POWER;
		last_step  = 3'd1;
		for (int i = MASK_W - 1; i >= 0; i--) begin
			if (mask_q[i]) cur_slot = 3'(i);
		end
		case (desc_q.kind)
			SEQ_PLAIN: begin
				if (cur_slot == BTN_POWER) begin
					ev_rst              = 1'b1;
					mask_next[cur_slot] = 1'b0;
				end else begin
					ev_code = plain_code(cur_slot);
					ev_down = ~phase_q;
					if (phase_q) begin
						mask_next[cur_slot] = 1'b0;
						phase_next          = 1'b0;
					end else begin
						phase_next = 1'b1;
					end
				end
				ev_last = (mask_next == '0);
			end
			SEQ_REPLAY: begin
				last_step = desc_q.caps_evt ? 3'd6 : 3'd5;
				ev_down   = ~step_q[0];
				case (step_q[2:1])
					2'd0:    ev_code = KEY_DELETE;
					2'd1:    ev_code = desc_q.code;
					2'd2:    ev_code = KEY_LEFT;
					default: begin
						ev_code = KEY_SHIFT;
						ev_down = desc_q.caps_down;
					end
				endcase
				ev_last = (step_q == last_step);
			end
			SEQ_TAP: begin
				ev_code = desc_q.code;
				ev_down = ~step_q[0];
				ev_last = (step_q == last_step);
			end
			SEQ_TAP_TWO: begin
				last_step = 3'd3;
				ev_code   = step_q[1] ? KEY_DELETE : KEY_LEFT;
				ev_down   = ~step_q[0];
				ev_last   = (step_q == last_step);
			end
			SEQ_POWER: begin
				// ctrl down, c down, c up, ctrl up
				last_step = 3'd3;
				ev_code   = (step_q[0] ^ step_q[1]) ? KEY_C : KEY_CTRL;
				ev_down   = ~step_q[1];
				ev_last   = (step_q == last_step);
			end
			default: begin
				ev_last = 1'b1;
			end
		endcase
	end

	// control: busy flag and result-register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) busy_q <= 1'b1;
			else if (adv && ev_last) busy_q <= 1'b0;
			if (adv) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
		end
	end

	// descriptor, progress and result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			desc_q  <= q_desc;
			mask_q  <= q_desc.mask;
			step_q  <= 3'd0;
			phase_q <= 1'b0;
		end else if (adv) begin
			mask_q  <= mask_next;
			step_q  <= step_q + 3'd1;
			phase_q <= phase_next;
		end
		if (adv) begin
			scancode_q      <= ev_code;
			key_down_q      <= ev_down;
			reset_request_q <= ev_rst;
			last_q          <= ev_last;
		end
	end

	`ASSERT_IMPLIES(a_plain_has_work, clk, arst_n, busy_q && desc_q.kind == SEQ_PLAIN, mask_q != '0)
	`ASSERT_IMPLIES(a_step_bound, clk, arst_n, busy_q && desc_q.kind != SEQ_PLAIN, step_q <= 3'd6)
	`ASSERT_NEXT(a_result_held, clk, arst_n, out_valid_q && !pop, out_valid_q && $stable(scancode_q))

endmodule

### rtl/core/button_to_scancode_encoder.sv
// Button-to-scancode encoder. A poll transaction is taken in any cycle the descriptor queue has room.
// A poll's first result goes through the queue storage, the back-end descriptor and the result register.
// The back end emits one result per cycle while the result register is free or popped, after loading
// each poll's descriptor from the queue; a poll gives up to 13 results, and two polls can wait in the queue.
// Reset (arst_n low) clears position, caps flag, queue and result register; no clearing pass.
module button_to_scancode_encoder #(
	parameter int CODE_COUNT = bsc_pkg::CODE_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] button_bits_low,
	input  logic [7:0] button_bits_high,
	output logic       empty,
	input  logic       pop,
	output logic [6:0] scancode,
	output logic       key_down,
	output logic       reset_request,
	output logic       last
);
	import bsc_pkg::*;

	logic      q_push;
	logic      q_full;
	logic      q_pop;
	logic      q_empty;
	seq_desc_t q_wdata;
	seq_desc_t q_rdata;

	// classifier and kept state
	bsc_front #(
		.CODE_COUNT(CODE_COUNT)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.button_bits_low  (button_bits_low),
		.button_bits_high (button_bits_high),
		.q_push           (q_push),
		.q_full           (q_full),
		.q_desc           (q_wdata)
	);

	// decoupling queue
	bsc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	// event sequencer and result register
	bsc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.q_desc        (q_rdata),
		.pop           (pop),
		.empty         (empty),
		.scancode      (scancode),
		.key_down      (key_down),
		.reset_request (reset_request),
		.last          (last)
	);

endmodule

### tb/scancode_checker.sv
// key event predictor and result comparator for the button to scancode encoder
// depends on bsc_pkg for key codes; watches the poll and key event channels of the dut
module scancode_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [7:0] button_bits_low,
	input  logic [7:0] button_bits_high,
	input  logic       empty,
	input  logic       pop,
	input  logic [6:0] scancode,
	input  logic       key_down,
	input  logic       reset_request,
	input  logic       last,
	output int         mismatches,
	output int         pending_keys
);
	import bsc_pkg::*;

	localparam int CHAR_COUNT = 48;
	localparam int MAX_REPORTS = 10;

	// button bit positions within the two poll bytes
	localparam int LO_OK    = 2;
	localparam int LO_ESC   = 3;
	localparam int LO_UP    = 4;
	localparam int LO_DOWN  = 5;
	localparam int LO_RIGHT = 6;
	localparam int LO_LEFT  = 7;
	localparam int HI_SHIFT = 4;
	localparam int HI_POWER = 7;

	// characters replayed by shifted up and down
	localparam logic [6:0] CHAR_CODES [CHAR_COUNT] = '{
		7'h1e, 7'h30, 7'h2e, 7'h20, 7'h12, 7'h21, 7'h22, 7'h23,
		7'h17, 7'h24, 7'h25, 7'h26, 7'h32, 7'h31, 7'h18, 7'h19,
		7'h10, 7'h13, 7'h1f, 7'h14, 7'h16, 7'h2f, 7'h11, 7'h2d,
		7'h15, 7'h2c, 7'h39, 7'h02, 7'h03, 7'h04, 7'h05, 7'h06,
		7'h07, 7'h08, 7'h09, 7'h0a, 7'h0b, 7'h29, 7'h0c, 7'h0d,
		7'h1a, 7'h1b, 7'h27, 7'h28, 7'h2b, 7'h33, 7'h34, 7'h35
	};

	typedef struct packed {
		logic [6:0] code;
		logic       down;
		logic       rst;
		logic       last;
	} key_event_t;

	key_event_t expected_keys[$];
	logic [5:0] char_pos = '0;
	logic       caps_on  = 1'b0;

	task automatic add_key(input logic [6:0] code, input logic down, input logic rst);
		key_event_t ev;
		ev.code = code;
		ev.down = down;
		ev.rst  = rst;
		ev.last = 1'b0;
		expected_keys.push_back(ev);
	endtask

	task automatic add_tap(input logic [6:0] code);
		add_key(code, 1'b1, 1'b0);
		add_key(code, 1'b0, 1'b0);
	endtask

	// wrap of the position flips caps and sends shift
	task automatic wrap_caps();
		if (caps_on) begin
			caps_on = 1'b0;
			add_key(KEY_SHIFT, 1'b0, 1'b0);
		end else begin
			caps_on = 1'b1;
			add_key(KEY_SHIFT, 1'b1, 1'b0);
		end
	endtask

	// delete, the character at the kept position, then cursor left
	task automatic add_replay();
		add_tap(KEY_DELETE);
		add_tap(int'(char_pos) < CHAR_COUNT ? CHAR_CODES[char_pos] : KEY_NONE);
		add_tap(KEY_LEFT);
	endtask

	// key events caused by one poll transaction
	task automatic encode_poll(input logic [7:0] lo, input logic [7:0] hi);
		int start;
		start = expected_keys.size();
		if (hi[HI_SHIFT]) begin
			if (lo[LO_UP]) begin
				add_replay();
				if (int'(char_pos) >= CHAR_COUNT - 1) begin
					char_pos = '0;
					wrap_caps();
				end else begin
					char_pos = char_pos + 6'd1;
				end
			end else if (lo[LO_DOWN]) begin
				add_replay();
				if (char_pos == '0) begin
					char_pos = 6'(CHAR_COUNT - 1);
					wrap_caps();
				end else begin
					char_pos = char_pos - 6'd1;
				end
			end else if (lo[LO_RIGHT]) begin
				add_tap(KEY_RIGHT);
			end else if (lo[LO_LEFT]) begin
				add_tap(KEY_LEFT);
			end else if (lo[LO_OK]) begin
				add_tap(KEY_SPACE);
			end else if (lo[LO_ESC]) begin
				add_tap(KEY_LEFT);
				add_tap(KEY_DELETE);
			end else if (hi[HI_POWER]) begin
				add_key(KEY_CTRL, 1'b1, 1'b0);
				add_key(KEY_C, 1'b1, 1'b0);
				add_key(KEY_C, 1'b0, 1'b0);
				add_key(KEY_CTRL, 1'b0, 1'b0);
			end
		end else begin
			if (lo[LO_OK])    add_tap(KEY_ENTER);
			if (lo[LO_ESC])   add_tap(KEY_ESC);
			if (lo[LO_UP])    add_tap(KEY_UP);
			if (lo[LO_DOWN])  add_tap(KEY_DOWN);
			if (lo[LO_RIGHT]) add_tap(KEY_RIGHT);
			if (lo[LO_LEFT])  add_tap(KEY_LEFT);
			if (hi[HI_POWER]) add_key(KEY_NONE, 1'b0, 1'b1);
		end
		if (expected_keys.size() > start)
			expected_keys[expected_keys.size() - 1].last = 1'b1;
	endtask

	// compare one key event transaction with the oldest expectation
	task automatic check_key();
		key_event_t want;
		key_event_t got;
		got.code = scancode;
		got.down = key_down;
		got.rst  = reset_request;
		got.last = last;
		if (expected_keys.size() == 0) begin
			mismatches = mismatches + 1;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: unexpected key event code=%0h down=%0b rst=%0b last=%0b",
					$realtime, got.code, got.down, got.rst, got.last);
		end else begin
			want = expected_keys.pop_front();
			if (got !== want) begin
				mismatches = mismatches + 1;
				if (mismatches <= MAX_REPORTS)
					$display({"%0t: key event mismatch exp code=%0h down=%0b rst=%0b last=%0b,",
						" got code=%0h down=%0b rst=%0b last=%0b"},
						$realtime, want.code, want.down, want.rst, want.last,
						got.code, got.down, got.rst, got.last);
			end
		end
	endtask

	// sample both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_pos = '0;
			caps_on  = 1'b0;
			expected_keys.delete();
		end else begin
			if (pop && !empty)
				check_key();
			if (push && !full)
				encode_poll(button_bits_low, button_bits_high);
		end
		pending_keys = expected_keys.size();
	end

endmodule

### tb/tb_button_to_scancode_encoder.sv
// top of the button to scancode encoder testbench: clock, reset, poll and pop stimulus, verdict
// depends on bsc_pkg, button_to_scancode_encoder and scancode_checker
module tb_button_to_scancode_encoder;
	import bsc_pkg::*;

	localparam int RANDOM_POLLS = 205;

	logic       clk              = 1'b0;
	logic       arst_n           = 1'b0;
	logic       push             = 1'b0;
	logic       pop              = 1'b0;
	logic [7:0] button_bits_low  = '0;
	logic [7:0] button_bits_high = '0;
	logic       full;
	logic       empty;
	logic [6:0] scancode;
	logic       key_down;
	logic       reset_request;
	logic       last;
	int         mismatch_count;
	int         pending_keys;

	// directed polls: low byte, high byte
	localparam logic [15:0] DIRECTED [25] = '{
		16'h00_00, 16'hff_ff, 16'h00_10, 16'h04_00, 16'h08_00,
		16'h10_00, 16'h20_00, 16'h40_00, 16'h80_00, 16'h00_80,
		16'hff_ef, 16'h03_6f, 16'h20_10, 16'h20_10, 16'h10_10,
		16'h20_10, 16'h40_10, 16'h80_10, 16'h04_10, 16'h08_10,
		16'h00_90, 16'h0c_90, 16'hc0_10, 16'h30_10, 16'h03_7f
	};

	button_to_scancode_encoder dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.button_bits_low  (button_bits_low),
		.button_bits_high (button_bits_high),
		.empty            (empty),
		.pop              (pop),
		.scancode         (scancode),
		.key_down         (key_down),
		.reset_request    (reset_request),
		.last             (last)
	);

	scancode_checker u_key_chk (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.button_bits_low  (button_bits_low),
		.button_bits_high (button_bits_high),
		.empty            (empty),
		.pop              (pop),
		.scancode         (scancode),
		.key_down         (key_down),
		.reset_request    (reset_request),
		.last             (last),
		.mismatches       (mismatch_count),
		.pending_keys     (pending_keys)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#3000000;
		$display("tb_button_to_scancode_encoder: errors");
		$finish;
	end

	// offer one poll transaction, with an optional random gap first
	task automatic send_poll(input logic [7:0] lo, input logic [7:0] hi, input bit may_idle);
		int gap;
		gap = 0;
		if (may_idle && $urandom_range(0, 99) < 30)
			gap = $urandom_range(1, 2);
		repeat (gap) begin
			@(negedge clk);
			push             <= 1'b0;
			button_bits_low  <= 8'($urandom);
			button_bits_high <= 8'($urandom);
		end
		@(negedge clk);
		push             <= 1'b1;
		button_bits_low  <= lo;
		button_bits_high <= hi;
		do @(posedge clk); while (full);
	endtask

	// poll stimulus and verdict
	initial begin
		int mode;
		logic [7:0] lo;
		logic [7:0] hi;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		foreach (DIRECTED[i])
			send_poll(DIRECTED[i][15:8], DIRECTED[i][7:0], 1'b1);
		// mostly shifted up and down so the position walks and wraps
		for (int i = 0; i < RANDOM_POLLS; i++) begin
			mode = $urandom_range(0, 9);
			lo = 8'($urandom);
			hi = 8'($urandom);
			case (mode)
				0, 1, 2, 3: begin
					lo = lo | 8'h10;
					hi = hi | 8'h10;
				end
				4: begin
					lo = (lo & 8'hef) | 8'h20;
					hi = hi | 8'h10;
				end
				5: begin
					lo = lo & 8'hcf;
					hi = hi | 8'h10;
				end
				6, 7: begin
					hi = hi & 8'hef;
				end
				default: begin
				end
			endcase
			send_poll(lo, hi, !(i >= 120 && i < 170));
		end
		@(negedge clk);
		push <= 1'b0;
		do @(negedge clk); while (pending_keys != 0);
		repeat (20) @(negedge clk);
		if (mismatch_count == 0)
			$display("tb_button_to_scancode_encoder: clean");
		else
			$display("tb_button_to_scancode_encoder: errors");
		$finish;
	end

	// key event receiver: random pops, one long hold-off, one stretch of steady pops
	initial begin
		int cyc;
		cyc = 0;
		forever begin
			@(negedge clk);
			cyc++;
			if (cyc >= 400 && cyc < 650)
				pop <= 1'b0;
			else if (cyc >= 1200 && cyc < 1800)
				pop <= 1'b1;
			else
				pop <= ($urandom_range(0, 99) >= 30);
		end
	end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/bsc_pkg.sv
rtl/core/bsc_queue.sv
rtl/core/bsc_front.sv
rtl/core/bsc_back.sv
rtl/core/button_to_scancode_encoder.sv
tb/scancode_checker.sv
tb/tb_button_to_scancode_encoder.sv
